/* rtl/bfiq_pkg.sv */
package bfiq_pkg;

	localparam int unsigned MAX_BITS_DEF   = 16384;
	localparam int unsigned MAX_HASHES_DEF = 64;
	localparam int unsigned BC_W           = 15;
	localparam int unsigned HC_W           = 7;
	localparam int unsigned CFG_W          = 15;
	localparam int unsigned HASH_W         = 32;
	localparam logic [HASH_W-1:0] HASH_MUL = 32'd101;

	typedef enum logic [0:0] {
		REG_BIT_COUNT  = 1'b0,
		REG_HASH_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef struct packed {
		logic       op;
		logic [7:0] key_byte;
		logic       key_last;
	} in_item_t;

	typedef struct packed {
		logic was_query;
		logic maybe_present;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_MEM,
		ST_CHECK,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic absorb;      // fold byte into base and power
		logic probe_start; // form hash of current seed, start remainder
		logic mod_step;    // one remainder step
		logic mem_access;  // read / write the probed bit
		logic acc_check;   // fold the read bit into the answer
		logic seed_next;   // advance to the next seed
		logic key_done;    // clear per-key state
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mod_done;
		logic last_seed;
		logic no_probes;
		logic clearing;    // bit store sweep after reset still running
	} dp_stat_t;

endpackage

/* rtl/bloom_filter_insert_query_core.sv */
// Bloom filter, insert and query over byte-string keys. Key bytes go in one
// item per cycle while busy is low; a non-final byte is absorbed and busy stays low. The
// final byte (key_last) holds busy high while each of the hash_count seeded
// probes is formed (one registered seed-by-power multiply) and reduced modulo
// bit_count by a restoring remainder unit, one bit a cycle. Each probe runs
// form, load, 32 remainder steps, bit access and check; with hash_count
// zero no probe runs. Then one result item shows for a single cycle on
// done/result; it cannot be held.
// After reset the bit store is swept clear, one bit a cycle, with busy high;
// configuration writes are taken meanwhile.
module bloom_filter_insert_query_core #(
	parameter int unsigned MAX_BITS   = bfiq_pkg::MAX_BITS_DEF,
	parameter int unsigned MAX_HASHES = bfiq_pkg::MAX_HASHES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bfiq_pkg::in_item_t         item,
	output logic                       done,
	output bfiq_pkg::out_item_t        result,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_idx,
	input  logic [bfiq_pkg::CFG_W-1:0] cfg_data
);
	bfiq_pkg::dp_cmd_t  cmd;
	bfiq_pkg::dp_stat_t stat;
	logic all_set, op_q;

	bfiq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .key_last(item.key_last),
		.stat(stat), .busy(busy), .done(done), .cmd(cmd)
	);

	bfiq_datapath #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx[0]),
		.cfg_data(cfg_data), .in_item(item), .op_latch(start && !busy),
		.cmd(cmd), .stat(stat), .all_set(all_set), .op_q(op_q)
	);

	// only the op of the final byte counts
	assign result.was_query     = op_q;
	assign result.maybe_present = op_q && all_set;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_ins_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.was_query |-> !result.maybe_present)
		else $error("insert reported present");
endmodule

/* rtl/bfiq_datapath.sv */
module bfiq_datapath #(
	parameter int unsigned MAX_BITS   = bfiq_pkg::MAX_BITS_DEF,
	parameter int unsigned MAX_HASHES = bfiq_pkg::MAX_HASHES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [bfiq_pkg::CFG_W-1:0] cfg_data,
	input  bfiq_pkg::in_item_t  in_item,
	input  logic                op_latch,
	input  bfiq_pkg::dp_cmd_t   cmd,
	output bfiq_pkg::dp_stat_t  stat,
	output logic                all_set,
	output logic                op_q
);
	localparam int unsigned AW  = $clog2(MAX_BITS);
	localparam int unsigned MW  = $clog2(MAX_BITS + 1);
	localparam int unsigned SW  = $clog2(MAX_HASHES + 1);
	localparam int unsigned HW  = bfiq_pkg::HASH_W;
	localparam int unsigned CW  = $clog2(HW + 1);

	logic [bfiq_pkg::BC_W-1:0] bit_count_q;
	logic [bfiq_pkg::HC_W-1:0] hash_count_q;
	logic [HW-1:0] base_q, power_q;
	logic [SW-1:0] seed_q, probes;
	logic [MW-1:0] modv;
	logic [HW-1:0] quo_q;
	logic [MW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic          rd_s1;
	logic          mem [MAX_BITS];
	logic [MW:0]   rem_sh;
	logic [HW-1:0] prod;
	logic [HW-1:0] mul_q;
	logic          clr_en;
	logic [AW:0]   clr_q;
	logic [AW-1:0] clr_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= bfiq_pkg::BC_W'(10000);
			hash_count_q <= bfiq_pkg::HC_W'(7);
		end else if (cfg_we) begin
			if (cfg_idx == bfiq_pkg::REG_BIT_COUNT)
				bit_count_q <= cfg_data[bfiq_pkg::BC_W-1:0];
			else
				hash_count_q <= cfg_data[bfiq_pkg::HC_W-1:0];
		end
	end

	always_comb begin
		if (bit_count_q == '0)
			modv = MW'(1);
		else if (32'(bit_count_q) > MAX_BITS)
			modv = MW'(MAX_BITS);
		else
			modv = MW'(bit_count_q);
		if (32'(hash_count_q) > MAX_HASHES)
			probes = SW'(MAX_HASHES);
		else
			probes = SW'(hash_count_q);
	end

	assign prod   = HW'(32'(seed_q) * power_q);
	assign rem_sh = {rem_q[MW-1:0], quo_q[HW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			power_q <= HW'(1);
			seed_q  <= SW'(1);
			cnt_q   <= '0;
			all_set <= 1'b1;
			op_q    <= 1'b0;
		end else begin
			if (op_latch)
				op_q <= in_item.op;
			if (cmd.absorb) begin
				base_q  <= HW'(base_q * bfiq_pkg::HASH_MUL) +
					{{(HW-8){in_item.key_byte[7]}}, in_item.key_byte};
				power_q <= HW'(power_q * bfiq_pkg::HASH_MUL);
			end
			if (cmd.probe_start)
				cnt_q <= CW'(HW);
			else if (cmd.mod_step)
				cnt_q <= cnt_q - CW'(1);
			if (cmd.acc_check && !rd_s1)
				all_set <= 1'b0;
			if (cmd.seed_next)
				seed_q <= seed_q + SW'(1);
			if (cmd.key_done) begin
				base_q  <= '0;
				power_q <= HW'(1);
				seed_q  <= SW'(1);
				all_set <= 1'b1;
			end
		end
	end

	// hash product registered, then restoring remainder one bit a cycle
	always_ff @(posedge clk) begin
		mul_q <= prod;
		if (cmd.probe_start) begin
			quo_q <= mul_q + base_q;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			quo_q <= {quo_q[HW-2:0], 1'b0};
			if (rem_sh >= (MW+1)'(modv))
				rem_q <= rem_sh - (MW+1)'(modv);
			else
				rem_q <= rem_sh;
		end
		if (cmd.mod_step && cnt_q == CW'(1))
			idx_q <= (rem_sh >= (MW+1)'(modv)) ? AW'(rem_sh - (MW+1)'(modv))
			                                    : AW'(rem_sh);
	end

	// bit store, swept clear bit by bit after reset
	always_ff @(posedge clk) begin
		if (cmd.mem_access) begin
			if (op_q == bfiq_pkg::OP_INSERT)
				mem[idx_q] <= 1'b1;
			rd_s1 <= mem[idx_q];
		end else if (clr_en) begin
			mem[clr_addr] <= 1'b0;
		end
	end

	assign clr_en   = !clr_q[AW];
	assign clr_addr = clr_q[AW-1:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (clr_en)
			clr_q <= clr_q + (AW+1)'(1);
	end

	assign stat.mod_done  = (cnt_q == '0);
	assign stat.last_seed = (seed_q >= probes);
	assign stat.no_probes = (probes == '0);
	assign stat.clearing  = clr_en;
endmodule

/* rtl/bfiq_ctrl.sv */
module bfiq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               key_last,
	input  bfiq_pkg::dp_stat_t stat,
	output logic               busy,
	output logic               done,
	output bfiq_pkg::dp_cmd_t  cmd
);
	bfiq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bfiq_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		done    = 1'b0;
		// the clearing sweep after reset also holds input off
		busy    = (state_q != bfiq_pkg::ST_IDLE) || stat.clearing;
		case (state_q)
			bfiq_pkg::ST_IDLE: begin
				if (start && !busy) begin
					cmd.absorb = 1'b1;
					if (key_last)
						state_d = bfiq_pkg::ST_HASH;
				end
			end
			bfiq_pkg::ST_HASH: begin
				if (stat.no_probes)
					state_d = bfiq_pkg::ST_DONE;
				else begin
					cmd.probe_start = 1'b0;
					state_d = bfiq_pkg::ST_MOD;
				end
			end
			bfiq_pkg::ST_MOD: begin
				cmd.probe_start = 1'b1;
				state_d = bfiq_pkg::ST_CHECK;
			end
			bfiq_pkg::ST_CHECK: begin
				if (!stat.mod_done)
					cmd.mod_step = 1'b1;
				else begin
					cmd.mem_access = 1'b1;
					state_d = bfiq_pkg::ST_MEM;
				end
			end
			bfiq_pkg::ST_MEM: begin
				cmd.acc_check = 1'b1;
				if (stat.last_seed)
					state_d = bfiq_pkg::ST_DONE;
				else begin
					cmd.seed_next = 1'b1;
					state_d = bfiq_pkg::ST_HASH;
				end
			end
			bfiq_pkg::ST_DONE: begin
				done         = 1'b1;
				cmd.key_done = 1'b1;
				state_d      = bfiq_pkg::ST_IDLE;
			end
			default: state_d = bfiq_pkg::ST_IDLE;
		endcase
	end
endmodule
